[design/itcl_pkg.sv]
package itcl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SCAN_WINDOW = 10;
    // bisection needs at least two entries in the window to shrink it
    localparam int EFF_WINDOW  = (SCAN_WINDOW < 2) ? 2 : SCAN_WINDOW;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int TAG_W  = 10;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] stop;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BISECT,
        S_SCAN,
        S_RESP
    } state_t;

endpackage

[design/itcl_if.sv]
interface itcl_req_if;
    import itcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] entry_start;
    logic [TIME_W-1:0] entry_stop;
    logic [TAG_W-1:0]  entry_tag;
    logic [TIME_W-1:0] query_start;
    logic [TIME_W-1:0] query_stop;

    modport source (
        output valid, req_type, entry_start, entry_stop, entry_tag,
               query_start, query_stop,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_start, entry_stop, entry_tag,
               query_start, query_stop,
        output ready
    );
endinterface

interface itcl_rsp_if;
    import itcl_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  match_tag;

    modport source (
        output valid, status, match_tag,
        input  ready
    );
    modport sink (
        input  valid, status, match_tag,
        output ready
    );
endinterface

[design/interval_table_containment_lookup.sv]
// Channel  Dir  Word
// req      in   req_type, entry_start, entry_stop, entry_tag, query_start, query_stop
// rsp      out  status, match_tag
//
// Append, clear and unused codes go straight from accept to the result state.
// A query runs bisection steps (one table read each) until at most 10
// entries are left, then scans entries in order (one read each),
// all through the single port of the entry RAM.
// Reset (rst_n, async low) empties the table; the RAM itself is not cleared.
// One word is worked on at a time; a new word is taken while the last
// result still sits in the output register.
module interval_table_containment_lookup
    import itcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    itcl_req_if.sink     req,
    itcl_rsp_if.source   rsp
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]  qs_reg, qs_next;
    logic [TIME_W-1:0]  qe_reg, qe_next;
    logic [STAT_W-1:0]  res_stat_reg, res_stat_next;
    logic [TAG_W-1:0]   res_tag_reg, res_tag_next;
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;

    logic               ram_en;
    logic               ram_we;
    logic [CNT_W-1:0]   ram_addr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;

    logic               accept;
    logic               out_free;
    logic               below_qs;
    logic [CNT_W-1:0]   bis_lo;
    logic [CNT_W-1:0]   bis_hi;
    logic [CNT_W:0]     bis_sum;
    logic               bis_more;
    logic               skip;
    logic               stop_early;
    logic [CNT_W-1:0]   idx_inc;
    logic               scan_more;
    logic [CNT_W:0]     init_sum;

    localparam logic [CNT_W-1:0] WIN = CNT_W'(EFF_WINDOW);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    // bisection step on the entry read for idx_reg (the midpoint)
    assign below_qs = ram_rdata.start < qs_reg;
    assign bis_lo   = below_qs ? idx_reg : lo_reg;
    assign bis_hi   = below_qs ? hi_reg : idx_reg + CNT_W'(1);
    assign bis_sum  = {1'b0, bis_lo} + {1'b0, bis_hi};
    assign bis_more = (bis_hi - bis_lo) > WIN;
    assign init_sum = {1'b0, count_reg};

    // scan step on the entry read for idx_reg
    assign skip       = (qe_reg < ram_rdata.stop) || (qs_reg > ram_rdata.start);
    assign stop_early = qe_reg < ram_rdata.start;
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign scan_more  = idx_inc < count_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_QUERY && count_reg > WIN)
                        state_next = S_BISECT;
                    else if (req.req_type == REQ_QUERY && count_reg != '0)
                        state_next = S_SCAN;
                    else
                        state_next = S_RESP;
                end
            end
            S_BISECT:
            begin
                if (!bis_more)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!skip || !scan_more)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        qs_next        = qs_reg;
        qe_next        = qe_reg;
        res_stat_next  = res_stat_reg;
        res_tag_next   = res_tag_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_stat_next  = out_stat_reg;
        out_tag_next   = out_tag_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = idx_reg;
        ram_wdata      = '{start: req.entry_start, stop: req.entry_stop,
                           tag: req.entry_tag};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qs_next       = req.query_start;
                    qe_next       = req.query_stop;
                    res_stat_next = ST_OK;
                    res_tag_next  = '0;
                    case (req.req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg >= FULL_COUNT)
                                res_stat_next = ST_FULL;
                            else
                            begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                ram_addr   = count_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_QUERY:
                        begin
                            lo_next = '0;
                            hi_next = count_reg;
                            if (count_reg > WIN)
                            begin
                                idx_next = init_sum[CNT_W:1];
                                ram_en   = 1'b1;
                                ram_addr = init_sum[CNT_W:1];
                            end
                            else if (count_reg != '0)
                            begin
                                idx_next = '0;
                                ram_en   = 1'b1;
                                ram_addr = '0;
                            end
                            else
                                res_stat_next = ST_NOMATCH;
                        end
                        REQ_CLEAR:
                            count_next = '0;
                        default:
                            res_stat_next = ST_OK;
                    endcase
                end
            end
            S_BISECT:
            begin
                lo_next = bis_lo;
                hi_next = bis_hi;
                ram_en  = 1'b1;
                // next midpoint, or the first entry of the scan
                if (bis_more)
                    idx_next = bis_sum[CNT_W:1];
                else
                    idx_next = bis_lo;
                ram_addr = idx_next;
            end
            S_SCAN:
            begin
                if (!skip)
                begin
                    if (stop_early)
                        res_stat_next = ST_NOMATCH;
                    else
                    begin
                        res_stat_next = ST_OK;
                        res_tag_next  = ram_rdata.tag;
                    end
                end
                else if (scan_more)
                begin
                    idx_next = idx_inc;
                    ram_en   = 1'b1;
                    ram_addr = idx_inc;
                end
                else
                    res_stat_next = ST_NOMATCH;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = res_stat_reg;
                    out_tag_next   = res_tag_reg;
                end
            end
            default:
                ram_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        qs_reg       <= qs_next;
        qe_reg       <= qe_next;
        res_stat_reg <= res_stat_next;
        res_tag_reg  <= res_tag_next;
        out_stat_reg <= out_stat_next;
        out_tag_reg  <= out_tag_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_stat_reg;
    assign rsp.match_tag = out_tag_reg;

    itcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

[design/itcl_ram.sv]
module itcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

[bench/testbench.sv]
module testbench;
    import itcl_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int TAIL_WORDS = 120;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [TIME_W-1:0] e_start;
        logic [TIME_W-1:0] e_stop;
        logic [TAG_W-1:0]  e_tag;
        logic [TIME_W-1:0] q_start;
        logic [TIME_W-1:0] q_stop;
        bit                hold;
    } req_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
    } answer_t;

    logic clk;
    logic rst_n;

    itcl_req_if req_ch();
    itcl_rsp_if rsp_ch();

    interval_table_containment_lookup DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    req_word_t         pending_words[$];
    answer_t           awaited_answers[$];
    int                words_taken;
    int                mismatches;
    int                total_words;
    bit                hold_next;

    // predictor copy of the interval table
    logic [TIME_W-1:0] tbl_start[TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_stop[TABLE_DEPTH];
    logic [TAG_W-1:0]  tbl_tag[TABLE_DEPTH];
    int unsigned       tbl_fill;

    // what the stimulus side believes the table holds
    logic [TIME_W-1:0] shadow_start[$];
    logic [TIME_W-1:0] shadow_stop[$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #64000000;
        $display("status: fail");
        $finish;
    end

    function automatic answer_t table_response(req_word_t w);
        answer_t     a;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned i;
        a.status = ST_OK;
        a.tag = '0;
        case (w.kind)
            REQ_APPEND:
            begin
                if (tbl_fill >= TABLE_DEPTH)
                begin
                    a.status = ST_FULL;
                end
                else
                begin
                    tbl_start[tbl_fill] = w.e_start;
                    tbl_stop[tbl_fill] = w.e_stop;
                    tbl_tag[tbl_fill] = w.e_tag;
                    tbl_fill++;
                end
            end
            REQ_QUERY:
            begin
                a.status = ST_NOMATCH;
                lo = 0;
                hi = tbl_fill;
                while (hi - lo > EFF_WINDOW)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_start[mid] < w.q_start)
                        lo = mid;
                    else
                        hi = (mid + 1 < tbl_fill) ? mid + 1 : tbl_fill;
                end
                for (i = lo; i < tbl_fill; i++)
                begin
                    if (w.q_stop < tbl_stop[i] || w.q_start > tbl_start[i])
                        continue;
                    // first candidate decides: inside, or starts past query stop
                    if (w.q_stop >= tbl_start[i])
                    begin
                        a.status = ST_OK;
                        a.tag = tbl_tag[i];
                    end
                    break;
                end
            end
            REQ_CLEAR:
            begin
                tbl_fill = 0;
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic bit idling_allowed();
        return pending_words.size() >= TAIL_WORDS && ((words_taken / 64) % 4) != 3;
    endfunction

    function automatic logic [TIME_W-1:0] sat_move(logic [TIME_W-1:0] v, int d);
        longint r;
        r = longint'(v) + d;
        if (r < 0)
            r = 0;
        if (r > 64'hFFFF_FFFF)
            r = 64'hFFFF_FFFF;
        return r[TIME_W-1:0];
    endfunction

    // sender: one word per handshake, random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        req_word_t nxt;
        int        gap_left;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= REQ_APPEND;
            req_ch.entry_start <= '0;
            req_ch.entry_stop <= '0;
            req_ch.entry_tag <= '0;
            req_ch.query_start <= '0;
            req_ch.query_stop <= '0;
            gap_left = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                nxt.kind = req_ch.req_type;
                nxt.e_start = req_ch.entry_start;
                nxt.e_stop = req_ch.entry_stop;
                nxt.e_tag = req_ch.entry_tag;
                nxt.q_start = req_ch.query_start;
                nxt.q_stop = req_ch.query_stop;
                awaited_answers.push_back(table_response(nxt));
                words_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         !(pending_words[0].hold && awaited_answers.size() != 0))
                begin
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                    begin
                        req_ch.valid <= 1'b0;
                        gap_left = $urandom_range(0, 16);
                    end
                    else
                    begin
                        nxt = pending_words.pop_front();
                        req_ch.valid <= 1'b1;
                        req_ch.req_type <= nxt.kind;
                        req_ch.entry_start <= nxt.e_start;
                        req_ch.entry_stop <= nxt.e_stop;
                        req_ch.entry_tag <= nxt.e_tag;
                        req_ch.query_start <= nxt.q_start;
                        req_ch.query_stop <= nxt.q_stop;
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        int      stall_left;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word st=%0d tag=%h", $realtime,
                                 rsp_ch.status, rsp_ch.match_tag);
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.match_tag !== want.tag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: got st=%0d tag=%h want st=%0d tag=%h", $realtime,
                                     rsp_ch.status, rsp_ch.match_tag, want.status, want.tag);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_word(logic [REQ_W-1:0] kind, logic [TIME_W-1:0] s,
                             logic [TIME_W-1:0] e, logic [TAG_W-1:0] t,
                             logic [TIME_W-1:0] qs, logic [TIME_W-1:0] qe);
        req_word_t w;
        w.kind = kind;
        w.e_start = s;
        w.e_stop = e;
        w.e_tag = t;
        w.q_start = qs;
        w.q_stop = qe;
        w.hold = hold_next;
        hold_next = 1'b0;
        pending_words.push_back(w);
        total_words++;
    endtask

    task automatic add_entry(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                             logic [TAG_W-1:0] t);
        push_word(REQ_APPEND, s, e, t, $urandom, $urandom);
        if (shadow_start.size() < TABLE_DEPTH)
        begin
            shadow_start.push_back(s);
            shadow_stop.push_back(e);
        end
    endtask

    task automatic add_query(logic [TIME_W-1:0] qs, logic [TIME_W-1:0] qe);
        push_word(REQ_QUERY, $urandom, $urandom, $urandom_range(0, 1023), qs, qe);
    endtask

    task automatic add_clear();
        push_word(REQ_CLEAR, $urandom, $urandom, $urandom_range(0, 1023), $urandom, $urandom);
        shadow_start.delete();
        shadow_stop.delete();
    endtask

    // mostly queries built around a stored interval, some pure noise
    task automatic add_probe();
        int                k;
        logic [TIME_W-1:0] qs;
        logic [TIME_W-1:0] qe;
        if (shadow_start.size() == 0 || $urandom_range(0, 4) == 0)
        begin
            qs = $urandom;
            qe = ($urandom_range(0, 1) == 0) ? $urandom : sat_move(qs, $urandom_range(0, 100000));
        end
        else
        begin
            k = $urandom_range(0, shadow_start.size() - 1);
            qs = ($urandom_range(0, 1) == 0) ? shadow_start[k]
                 : sat_move(shadow_start[k], -$urandom_range(1, 3000));
            case ($urandom_range(0, 5))
                0: qe = shadow_stop[k];
                1: qe = sat_move(shadow_start[k], -1);
                2: qe = sat_move(shadow_stop[k], -$urandom_range(1, 50));
                default: qe = sat_move(shadow_stop[k], $urandom_range(0, 3000));
            endcase
        end
        add_query(qs, qe);
    endtask

    function automatic logic [TIME_W-1:0] make_stop(logic [TIME_W-1:0] s);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return sat_move(s, -$urandom_range(1, 500));
            2: return s;
            default: return sat_move(s, $urandom_range(0, 5000));
        endcase
    endfunction

    // mode 0: sorted over full range, 1: sorted with many equal starts, 2: unsorted
    task automatic run_phase(int n, int mode);
        logic [TIME_W-1:0] starts[$];
        logic [TIME_W-1:0] base;
        int                i;
        if (shadow_start.size() + n > TABLE_DEPTH || $urandom_range(0, 5) != 0)
            add_clear();
        base = $urandom;
        for (i = 0; i < n; i++)
            starts.push_back((mode == 1) ? sat_move(base, $urandom_range(0, 15)) : $urandom);
        if (mode != 2)
            starts.sort();
        for (i = 0; i < n; i++)
        begin
            add_entry(starts[i], make_stop(starts[i]), $urandom_range(0, 1023));
            if ($urandom_range(0, 3) == 0)
                add_probe();
            if ($urandom_range(0, 39) == 0)
                push_word(REQ_UNUSED, $urandom, $urandom, $urandom_range(0, 1023),
                          $urandom, $urandom);
        end
        repeat ($urandom_range(4, 16)) add_probe();
    endtask

    initial
    begin
        rst_n = 1'b0;
        words_taken = 0;
        mismatches = 0;
        total_words = 0;
        hold_next = 1'b0;
        tbl_fill = 0;

        // directed: empty table, extremes, inverted interval, unused code, clear
        add_query(32'h0, 32'hFFFF_FFFF);
        push_word(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_entry(32'h0, 32'h0, 10'h0);
        add_entry(32'd5, 32'd3, 10'h2AA);
        add_entry(32'd100, 32'd200, 10'h155);
        add_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        add_query(32'h0, 32'h0);
        add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_query(32'd1, 32'd4);
        add_query(32'd100, 32'd200);
        add_query(32'd101, 32'd300);
        add_query(32'h0, 32'hFFFF_FFFF);
        push_word(REQ_UNUSED, 32'h0, 32'h0, 10'h0, 32'h0, 32'h0);
        add_query(32'd100, 32'd200);
        add_clear();
        add_query(32'h0, 32'hFFFF_FFFF);
        add_entry(32'd7, 32'd9, 10'h1);
        add_query(32'd7, 32'd9);

        // sender waits for the pipeline to empty before this phase
        hold_next = 1'b1;
        run_phase(12, 0);
        while (total_words < 780)
            run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                      : $urandom_range(0, 40), $urandom_range(0, 2));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_ch.valid || awaited_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
design/itcl_pkg.sv
design/itcl_if.sv
design/itcl_ram.sv
design/interval_table_containment_lookup.sv
bench/testbench.sv
